>>> sv/tlc_pkg.sv
`timescale 1ns / 1ps

package tlc_pkg;

    localparam int unsigned CFG_W   = 60;   // widest configuration register
    localparam int unsigned AP_W    = 16;   // aperture radius, unsigned Q4.12
    localparam int unsigned IN_W    = 16;   // Q0.16 input fractions
    localparam int unsigned SIN_W   = 17;   // sine magnitude, Q1.15, up to 1.0
    localparam int unsigned TRIG_W  = 18;   // signed sine / cosine
    localparam int unsigned RDX_W   = 32;   // lens offset scale, rad * trig
    localparam int unsigned STAGES  = 10;   // pipeline depth

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // (2n)(2n+1) for the Taylor terms n = 1..10
    localparam longint unsigned TAYLOR_DIV [10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    typedef enum logic [2:0] {
        CFG_CAM_POS,
        CFG_BASIS_U,
        CFG_BASIS_V,
        CFG_PLANE_H,
        CFG_PLANE_V,
        CFG_PLANE_LL,
        CFG_APERTURE
    } t_cfg_idx;

    // Quarter-wave sine entry from a Q30 angle; elaboration time only.
    function automatic logic [SIN_W-1:0] sin_entry(input longint unsigned x);
        longint unsigned term;
        longint unsigned sum;
        longint unsigned e;
        term = x;
        sum  = x;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        e = (sum + 64'd16384) >> 15;
        if (e > 64'd32768) begin
            e = 64'd32768;
        end
        return e[SIN_W-1:0];
    endfunction

endpackage

>>> sv/tlc_sqrt.sv
`timescale 1ns / 1ps

// floor(sqrt(rr * 65536)), restoring digit recurrence, four result bits per stage
module tlc_sqrt (
    input  logic                        i_clk,
    input  logic [3:0]                  i_en,
    input  logic [tlc_pkg::IN_W-1:0]    i_rr,
    output logic [tlc_pkg::IN_W-1:0]    o_root
);
    import tlc_pkg::*;

    localparam int unsigned RAD_W = 2 * IN_W;
    localparam int unsigned REM_W = IN_W + 4;

    logic [RAD_W-1:0] r_rad  [0:3];
    logic [REM_W-1:0] r_rem  [0:3];
    logic [IN_W-1:0]  r_root [0:3];

    for (genvar s = 0; s < 4; s++) begin : g_stage
        logic [RAD_W-1:0] w_rad_in;
        logic [REM_W-1:0] w_rem_in;
        logic [IN_W-1:0]  w_root_in;
        logic [RAD_W-1:0] n_rad;
        logic [REM_W-1:0] n_rem;
        logic [IN_W-1:0]  n_root;

        if (s == 0) begin : g_first
            assign w_rad_in  = {i_rr, {IN_W{1'b0}}};
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rad_in  = r_rad[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
        end

        always_comb begin
            logic [REM_W-1:0] trial;
            n_rad  = w_rad_in;
            n_rem  = w_rem_in;
            n_root = w_root_in;
            for (int b = 0; b < 4; b++) begin
                n_rem = {n_rem[REM_W-3:0], n_rad[RAD_W-1 -: 2]};
                n_rad = {n_rad[RAD_W-3:0], 2'b00};
                trial = {2'b00, n_root, 2'b01};
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = {n_root[IN_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[IN_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rad[s]  <= n_rad;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_root = r_root[3];

endmodule

>>> sv/tlc_sincos.sv
`timescale 1ns / 1ps

// Registered sine and cosine lookup from a quarter-wave constant table
module tlc_sincos #(
    parameter int ANGLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [tlc_pkg::IN_W-1:0]            i_angle,
    output logic signed [tlc_pkg::TRIG_W-1:0]   o_sin,
    output logic signed [tlc_pkg::TRIG_W-1:0]   o_cos
);
    import tlc_pkg::*;

    localparam int unsigned QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int unsigned IDX_W   = ANGLE_BITS - 1;

    logic [SIN_W-1:0] w_rom [0:QUARTER];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
        localparam longint unsigned XQ30 = HALF_PI_Q30 * 64'(k) / 64'(QUARTER);
        localparam logic [SIN_W-1:0] VAL = sin_entry(XQ30);
        assign w_rom[k] = VAL;
    end

    logic [ANGLE_BITS-1:0] w_ps;
    logic [ANGLE_BITS-1:0] w_pc;
    logic [IDX_W-1:0]      w_is;
    logic [IDX_W-1:0]      w_ic;

    assign w_ps = i_angle[IN_W-1 -: ANGLE_BITS];
    assign w_pc = w_ps + ANGLE_BITS'(QUARTER);

    // odd quadrants read the table mirrored
    assign w_is = w_ps[ANGLE_BITS-2]
                ? IDX_W'(QUARTER) - {1'b0, w_ps[ANGLE_BITS-3:0]}
                : {1'b0, w_ps[ANGLE_BITS-3:0]};
    assign w_ic = w_pc[ANGLE_BITS-2]
                ? IDX_W'(QUARTER) - {1'b0, w_pc[ANGLE_BITS-3:0]}
                : {1'b0, w_pc[ANGLE_BITS-3:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= w_ps[ANGLE_BITS-1] ? -$signed({1'b0, w_rom[w_is]})
                                        :  $signed({1'b0, w_rom[w_is]});
            o_cos <= w_pc[ANGLE_BITS-1] ? -$signed({1'b0, w_rom[w_ic]})
                                        :  $signed({1'b0, w_rom[w_ic]});
        end
    end

endmodule

>>> sv/tlc_axis.sv
`timescale 1ns / 1ps

// One vector component: lens offset, origin and direction, four stages
module tlc_axis #(
    parameter int COORD_BITS = 20
) (
    input  logic                                i_clk,
    input  logic [3:0]                          i_en,
    input  logic signed [COORD_BITS-1:0]        i_pos,
    input  logic signed [COORD_BITS-1:0]        i_u,
    input  logic signed [COORD_BITS-1:0]        i_v,
    input  logic signed [COORD_BITS-1:0]        i_h,
    input  logic signed [COORD_BITS-1:0]        i_vv,
    input  logic signed [COORD_BITS-1:0]        i_ll,
    input  logic signed [tlc_pkg::RDX_W-1:0]    i_rdx,
    input  logic signed [tlc_pkg::RDX_W-1:0]    i_rdy,
    input  logic [tlc_pkg::IN_W-1:0]            i_ix,
    input  logic [tlc_pkg::IN_W-1:0]            i_iy,
    output logic signed [COORD_BITS-1:0]        o_origin,
    output logic signed [COORD_BITS-1:0]        o_dir
);
    import tlc_pkg::*;

    localparam int unsigned WP = COORD_BITS + RDX_W;       // basis * scale
    localparam int unsigned WS = WP + 1;                   // sum of two
    localparam int unsigned WI = COORD_BITS + IN_W + 1;    // fraction * plane
    localparam int unsigned WA = COORD_BITS + IN_W + 3;    // plane point, Q.26
    localparam int unsigned WO = WS - 27;                  // offset, Q.10
    localparam int unsigned WR = WA - 16;                  // plane point, Q.10
    localparam int unsigned WG = COORD_BITS + 7;           // before clamp

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [WG-1:0] v);
        logic ovf;
        ovf = !(&v[WG-1:COORD_BITS-1] || ~|v[WG-1:COORD_BITS-1]);
        if (!ovf) begin
            return v[COORD_BITS-1:0];
        end
        return v[WG-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    endfunction

    logic signed [WP-1:0] r_pu, r_pv;
    logic signed [WI-1:0] r_ph, r_pvv;
    logic signed [WS-1:0] r_sum;
    logic signed [WA-1:0] r_pa;
    logic signed [WO-1:0] r_off;
    logic signed [WR-1:0] r_par;
    logic signed [COORD_BITS-1:0] r_org, r_org_q, r_dir;

    logic signed [WS-1:0] w_sum_rnd;
    logic signed [WA-1:0] w_pa_rnd;
    logic signed [WO-1:0] w_off;
    logic signed [WG-1:0] w_org;
    logic signed [WG-1:0] w_dir;

    assign w_sum_rnd = r_sum + WS'(1 << 26);
    assign w_off     = $signed(w_sum_rnd[WS-1:27]);
    assign w_pa_rnd  = r_pa + WA'(1 << 15);
    assign w_org     = WG'(i_pos) + WG'(w_off);
    assign w_dir     = WG'(r_par) - WG'(r_off);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pu  <= WP'(i_u) * WP'(i_rdx);
            r_pv  <= WP'(i_v) * WP'(i_rdy);
            r_ph  <= WI'($signed({1'b0, i_ix})) * WI'(i_h);
            r_pvv <= WI'($signed({1'b0, i_iy})) * WI'(i_vv);
        end
        if (i_en[1]) begin
            r_sum <= WS'(r_pu) + WS'(r_pv);
            r_pa  <= (WA'(i_ll) <<< 16) + WA'(r_ph) + WA'(r_pvv);
        end
        if (i_en[2]) begin
            r_off <= w_off;
            r_org <= sat(w_org);
            r_par <= $signed(w_pa_rnd[WA-1:16]);
        end
        if (i_en[3]) begin
            r_dir   <= sat(w_dir);
            r_org_q <= r_org;
        end
    end

    assign o_origin = r_org_q;
    assign o_dir    = r_dir;

endmodule

>>> sv/thin_lens_camera_ray_gen_top.sv
`timescale 1ns / 1ps
// Thin-lens camera ray generator.
// Throughput: one sample per cycle when the output is not stalled; the ten register stages (square root
// over four, then radius scale, trig scale, products, sums, rounding, clamp) each hand on per clock.
// Reset (i_rst_n low, synchronous) empties the pipeline and zeroes all config registers.
module thin_lens_camera_ray_gen_top #(
    parameter int COORD_BITS = 20,
    parameter int ANGLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [tlc_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tlc_pkg::IN_W-1:0]        i_interp_x,
    input  logic [tlc_pkg::IN_W-1:0]        i_interp_y,
    input  logic [tlc_pkg::IN_W-1:0]        i_rand_angle,
    input  logic [tlc_pkg::IN_W-1:0]        i_rand_radius,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [COORD_BITS-1:0]    o_origin_x,
    output logic signed [COORD_BITS-1:0]    o_origin_y,
    output logic signed [COORD_BITS-1:0]    o_origin_z,
    output logic signed [COORD_BITS-1:0]    o_dir_x,
    output logic signed [COORD_BITS-1:0]    o_dir_y,
    output logic signed [COORD_BITS-1:0]    o_dir_z
);
    import tlc_pkg::*;

    logic [CFG_W-1:0] r_pos, r_bu, r_bv, r_ph, r_pv, r_pll;
    logic [AP_W-1:0]  r_ap;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_en;

    logic [IN_W-1:0] r_ix  [0:5];
    logic [IN_W-1:0] r_iy  [0:5];
    logic [IN_W-1:0] r_ang [0:3];

    logic [IN_W-1:0]            w_root;
    logic [2*IN_W-1:0]          w_rad_prod;
    logic [IN_W-1:0]            r_rad;
    logic signed [TRIG_W-1:0]   w_sin, w_cos;
    logic signed [RDX_W-1:0]    r_rdx, r_rdy;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_bu  <= '0;
            r_bv  <= '0;
            r_ph  <= '0;
            r_pv  <= '0;
            r_pll <= '0;
            r_ap  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAM_POS:  r_pos <= i_cfg_data;
                CFG_BASIS_U:  r_bu  <= i_cfg_data;
                CFG_BASIS_V:  r_bv  <= i_cfg_data;
                CFG_PLANE_H:  r_ph  <= i_cfg_data;
                CFG_PLANE_V:  r_pv  <= i_cfg_data;
                CFG_PLANE_LL: r_pll <= i_cfg_data;
                CFG_APERTURE: r_ap  <= i_cfg_data[AP_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // side data travelling with the square root
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ix[0]  <= i_interp_x;
            r_iy[0]  <= i_interp_y;
            r_ang[0] <= i_rand_angle;
        end
        for (int k = 1; k < 6; k++) begin
            if (w_en[k]) begin
                r_ix[k] <= r_ix[k-1];
                r_iy[k] <= r_iy[k-1];
            end
        end
        for (int k = 1; k < 4; k++) begin
            if (w_en[k]) begin
                r_ang[k] <= r_ang[k-1];
            end
        end
    end

    tlc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en[3:0]),
        .i_rr   (i_rand_radius),
        .o_root (w_root)
    );

    tlc_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_en    (w_en[4]),
        .i_angle (r_ang[3]),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    assign w_rad_prod = (2*IN_W)'(r_ap) * (2*IN_W)'(w_root);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_rad <= w_rad_prod[2*IN_W-1:IN_W];
        end
        if (w_en[5]) begin
            r_rdx <= RDX_W'($signed({1'b0, r_rad})) * RDX_W'(w_cos);
            r_rdy <= RDX_W'($signed({1'b0, r_rad})) * RDX_W'(w_sin);
        end
    end

    // vector registers zero-extended so every component slice is in range
    logic [63:0] w_pos, w_bu, w_bv, w_ph, w_pv, w_pll;
    assign w_pos = 64'(r_pos);
    assign w_bu  = 64'(r_bu);
    assign w_bv  = 64'(r_bv);
    assign w_ph  = 64'(r_ph);
    assign w_pv  = 64'(r_pv);
    assign w_pll = 64'(r_pll);

    logic signed [COORD_BITS-1:0] w_org [0:2];
    logic signed [COORD_BITS-1:0] w_dir [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_axis
        tlc_axis #(
            .COORD_BITS (COORD_BITS)
        ) u_axis (
            .i_clk    (i_clk),
            .i_en     (w_en[9:6]),
            .i_pos    ($signed(w_pos[c*COORD_BITS +: COORD_BITS])),
            .i_u      ($signed(w_bu[c*COORD_BITS +: COORD_BITS])),
            .i_v      ($signed(w_bv[c*COORD_BITS +: COORD_BITS])),
            .i_h      ($signed(w_ph[c*COORD_BITS +: COORD_BITS])),
            .i_vv     ($signed(w_pv[c*COORD_BITS +: COORD_BITS])),
            .i_ll     ($signed(w_pll[c*COORD_BITS +: COORD_BITS])),
            .i_rdx    (r_rdx),
            .i_rdy    (r_rdy),
            .i_ix     (r_ix[5]),
            .i_iy     (r_iy[5]),
            .o_origin (w_org[c]),
            .o_dir    (w_dir[c])
        );
    end

    assign o_origin_x = w_org[0];
    assign o_origin_y = w_org[1];
    assign o_origin_z = w_org[2];
    assign o_dir_x    = w_dir[0];
    assign o_dir_y    = w_dir[1];
    assign o_dir_z    = w_dir[2];

    // input side only blocks when every stage is full and the output is held
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld) && !i_out_ready)
        else $error("input blocked while pipeline has room");

    a_last_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-2] && w_en[STAGES-1] |=> o_out_valid)
        else $error("transaction lost entering output stage");

    a_zero_aperture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en[4] && r_vld[3] && r_ap == '0 |=> r_rad == '0)
        else $error("lens radius nonzero with zero aperture");

endmodule
